>>> src/page_frame_occupancy_marker_unit_assert.svh
// Assertion macros for the page frame occupancy marker.
`ifndef PAGE_FRAME_OCCUPANCY_MARKER_UNIT_ASSERT_SVH
`define PAGE_FRAME_OCCUPANCY_MARKER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define PFOM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define PFOM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pfom_pkg.sv
// Shared constants and types for the page frame occupancy marker.
package pfom_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned PRESENT_BIT = 63;
  localparam int unsigned FRAME_W     = 55;
  localparam int unsigned ENTRY_W     = 64;
  localparam int unsigned CNT_W       = 21;
  localparam int unsigned TALLY_W     = 32;
  localparam int unsigned OUT_DATA_W  = 112;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - (3 + 2 * CNT_W + 2 * TALLY_W);

  localparam logic [CNT_W-1:0] TOTAL_RESET = 21'h100000;

  typedef logic [WORD_BITS-1:0] bm_word_t;

  // counter bump requests, one completed entry at a time
  typedef struct packed {
    logic new_mark;
    logic shared;
    logic beyond;
  } pfom_event_t;

endpackage

>>> src/page_frame_occupancy_marker_unit.sv
// Top level of the page frame occupancy marker.
// After reset the frame bitmap is swept to zero, one word per cycle, over
// all ceil(MAX_FRAMES/64) words (16384 at the default); s_axis_tready stays low
// until the sweep ends, while configuration writes are taken at any time.
// Each entry is then handled in order: its bitmap word is read, then the word
// is tested, set and written back, the counters are bumped and the result is
// loaded. A result waits in the output stage until taken, and no new entry is
// accepted until the current one completes, which it does once the output stage
// is free. The counts on m_axis_tdata are those after the entry shown.
module page_frame_occupancy_marker_unit #(
  parameter int unsigned MAX_FRAMES = 1048576
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // [63:0] map_entry
  input  logic [pfom_pkg::ENTRY_W-1:0]        s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] present_seen, [1] beyond_range, [2] already_marked, [23:3] used_total,
  // [44:24] free_total, [76:45] shared_total, [108:77] beyond_total, [111:109] 0
  output logic [pfom_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [pfom_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);

  localparam int unsigned WORDS =
    (MAX_FRAMES + pfom_pkg::WORD_BITS - 1) / pfom_pkg::WORD_BITS;
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned LIM_BITS = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CW = (LIM_BITS > pfom_pkg::CNT_W) ? LIM_BITS : pfom_pkg::CNT_W;

  logic [pfom_pkg::CNT_W-1:0] total_q;

  logic                            clearing;
  logic                            in_fire, complete;
  logic [pfom_pkg::FRAME_W-1:0]    frame;
  logic [CW-1:0]                   limit;
  logic                            present, beyond;

  logic                            busy_q;
  logic                            pres_q, beyond_q, last_q;
  logic [pfom_pkg::BIT_W-1:0]      bit_q;
  logic [AW-1:0]                   addr_q;

  pfom_pkg::bm_word_t              rd_word, wr_word;
  logic                            hit, new_mark, marked;
  pfom_pkg::pfom_event_t           ev;

  logic                            out_valid_q;
  logic                            o_pres_q, o_beyond_q, o_marked_q, o_last_q;

  logic [pfom_pkg::CNT_W-1:0]      used, free;
  logic [pfom_pkg::TALLY_W-1:0]    shared_cnt, beyond_cnt;
  logic                            used_bump;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= pfom_pkg::TOTAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_q <= cfg_data_i;
    end
  end

  // accept and classify
  assign s_axis_tready = !clearing && !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign frame   = s_axis_tdata[pfom_pkg::FRAME_W-1:0];
  assign present = s_axis_tdata[pfom_pkg::PRESENT_BIT];
  assign limit   = (CW'(total_q) < CW'(MAX_FRAMES)) ? CW'(total_q) : CW'(MAX_FRAMES);
  assign beyond  = present &&
                   ((|frame[pfom_pkg::FRAME_W-1:CW]) || (frame[CW-1:0] >= limit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (complete) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pres_q   <= present;
      beyond_q <= beyond;
      last_q   <= s_axis_tlast;
      bit_q    <= frame[pfom_pkg::BIT_W-1:0];
      addr_q   <= frame[pfom_pkg::BIT_W +: AW];
    end
  end

  pfom_bitmap #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (frame[pfom_pkg::BIT_W +: AW]),
    .rd_data_o  (rd_word),
    .wr_en_i    (complete && new_mark),
    .wr_addr_i  (addr_q),
    .wr_data_i  (wr_word),
    .clearing_o (clearing)
  );

  // test and set
  assign complete = busy_q && (!out_valid_q || m_axis_tready);
  assign hit      = rd_word[bit_q];
  assign new_mark = pres_q && !beyond_q && !hit;
  assign marked   = pres_q && !beyond_q && hit;
  assign wr_word  = rd_word | (pfom_pkg::bm_word_t'(1) << bit_q);

  assign ev.new_mark = complete && new_mark;
  assign ev.shared   = complete && marked;
  assign ev.beyond   = complete && beyond_q;

  pfom_tally u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ev_i     (ev),
    .total_i  (total_q),
    .used_o   (used),
    .free_o   (free),
    .shared_o (shared_cnt),
    .beyond_o (beyond_cnt)
  );

  // output stage; counters only move on completion, so they stay with the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (complete) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      o_pres_q   <= pres_q;
      o_beyond_q <= beyond_q;
      o_marked_q <= marked;
      o_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {{pfom_pkg::OUT_PAD_W{1'b0}}, beyond_cnt, shared_cnt, free, used,
                          o_marked_q, o_beyond_q, o_pres_q};

  assign used_bump = ev.new_mark && (used != '1);

`include "page_frame_occupancy_marker_unit_assert.svh"

  `PFOM_ASSERT_IMP(a_no_accept_busy, busy_q || clearing, !in_fire, "entry taken while busy")
  `PFOM_ASSERT_NXT(a_used_step, used_bump, used == $past(used) + 1'b1, "used count not bumped")
  `PFOM_ASSERT_IMP(a_free_sum, total_q >= used, (free + used) == total_q, "free count off")

endmodule

>>> src/pfom_bitmap.sv
// Frame bitmap memory with read port, write port and clearing pass after reset.
module pfom_bitmap #(
  parameter int unsigned WORDS = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output pfom_pkg::bm_word_t   rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  pfom_pkg::bm_word_t   wr_data_i,
  output logic                 clearing_o
);

  pfom_pkg::bm_word_t mem [WORDS];
  pfom_pkg::bm_word_t rd_data_q;

  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  pfom_pkg::bm_word_t mem_wdata;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(WORDS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign mem_we    = clearing_q | wr_en_i;
  assign mem_waddr = clearing_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

>>> src/pfom_tally.sv
// Saturating used, shared and out-of-range counters plus free count.
module pfom_tally (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfom_pkg::pfom_event_t         ev_i,
  input  logic [pfom_pkg::CNT_W-1:0]    total_i,
  output logic [pfom_pkg::CNT_W-1:0]    used_o,
  output logic [pfom_pkg::CNT_W-1:0]    free_o,
  output logic [pfom_pkg::TALLY_W-1:0]  shared_o,
  output logic [pfom_pkg::TALLY_W-1:0]  beyond_o
);

  logic [pfom_pkg::CNT_W-1:0]   used_q, used_d;
  logic [pfom_pkg::TALLY_W-1:0] shared_q, shared_d;
  logic [pfom_pkg::TALLY_W-1:0] beyond_q, beyond_d;

  always_comb begin
    used_d   = used_q;
    shared_d = shared_q;
    beyond_d = beyond_q;
    if (ev_i.new_mark && (used_q != '1)) begin
      used_d = used_q + 1'b1;
    end
    if (ev_i.shared && (shared_q != '1)) begin
      shared_d = shared_q + 1'b1;
    end
    if (ev_i.beyond && (beyond_q != '1)) begin
      beyond_d = beyond_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      shared_q <= '0;
      beyond_q <= '0;
    end else begin
      used_q   <= used_d;
      shared_q <= shared_d;
      beyond_q <= beyond_d;
    end
  end

  assign used_o   = used_q;
  assign free_o   = (total_i > used_q) ? (total_i - used_q) : '0;
  assign shared_o = shared_q;
  assign beyond_o = beyond_q;

endmodule

>>> bench/frame_occupancy_monitor.sv
// Checker for the page frame occupancy marker: predicts each result word and compares it.
module frame_occupancy_monitor #(
  parameter int unsigned MAX_FRAMES = 1048576
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // [63:0] map_entry
  input  logic [pfom_pkg::ENTRY_W-1:0]    s_axis_tdata,
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // [0] present_seen, [1] beyond_range, [2] already_marked, [23:3] used_total,
  // [44:24] free_total, [76:45] shared_total, [108:77] beyond_total, [111:109] 0
  input  logic [pfom_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [pfom_pkg::CNT_W-1:0]      cfg_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  output int unsigned                     outstanding_o,
  output int unsigned                     checked_o,
  output int unsigned                     mismatches_o
);
  import pfom_pkg::*;

  typedef struct packed {
    logic               scan_done;
    logic [TALLY_W-1:0] beyond_total;
    logic [TALLY_W-1:0] shared_total;
    logic [CNT_W-1:0]   free_total;
    logic [CNT_W-1:0]   used_total;
    logic               already_marked;
    logic               beyond_range;
    logic               present_seen;
  } frame_report_t;

  logic [CNT_W-1:0]   frame_limit = TOTAL_RESET;
  logic [CNT_W-1:0]   used_count = '0;
  logic [TALLY_W-1:0] shared_count = '0;
  logic [TALLY_W-1:0] beyond_count = '0;
  bit                 marked_frames [longint unsigned];
  frame_report_t      report_q [$];
  frame_report_t      want;
  frame_report_t      got;
  int unsigned        mismatch_count = 0;
  int unsigned        checked_count = 0;

  function automatic frame_report_t mark_entry(logic [ENTRY_W-1:0] entry, logic last);
    frame_report_t   r;
    longint unsigned frame;
    longint unsigned cap;
    r = '0;
    r.present_seen = entry[PRESENT_BIT];
    r.scan_done = last;
    if (r.present_seen) begin
      frame = entry[FRAME_W-1:0];
      cap = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
      if (frame >= cap) begin
        r.beyond_range = 1'b1;
        if (beyond_count != '1) beyond_count++;
      end else if (marked_frames.exists(frame)) begin
        r.already_marked = 1'b1;
        if (shared_count != '1) shared_count++;
      end else begin
        marked_frames[frame] = 1'b1;
        if (used_count != '1) used_count++;
      end
    end
    r.used_total = used_count;
    r.free_total = (frame_limit > used_count) ? frame_limit - used_count : '0;
    r.shared_total = shared_count;
    r.beyond_total = beyond_count;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want_v,
                                      longint unsigned got_v);
    if (want_v != got_v) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit = TOTAL_RESET;
      used_count = '0;
      shared_count = '0;
      beyond_count = '0;
      marked_frames.delete();
      report_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) frame_limit = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(mark_entry(s_axis_tdata, s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata[$bits(frame_report_t)-2:0]};
        if (report_q.size() == 0) begin
          mismatch_count++;
          $error("result word with no entry waiting");
        end else begin
          want = report_q.pop_front();
          checked_count++;
          check_field("present_seen", want.present_seen, got.present_seen);
          check_field("beyond_range", want.beyond_range, got.beyond_range);
          check_field("already_marked", want.already_marked, got.already_marked);
          check_field("used_total", want.used_total, got.used_total);
          check_field("free_total", want.free_total, got.free_total);
          check_field("shared_total", want.shared_total, got.shared_total);
          check_field("beyond_total", want.beyond_total, got.beyond_total);
          check_field("scan_done", want.scan_done, got.scan_done);
        end
      end
      outstanding_o <= report_q.size();
    end
  end

  assign checked_o = checked_count;
  assign mismatches_o = mismatch_count;

endmodule

>>> bench/page_frame_occupancy_marker_unit_tb.sv
// Testbench top for the page frame occupancy marker: stimulus, pacing and verdict.
module page_frame_occupancy_marker_unit_tb;
  import pfom_pkg::*;

  localparam int unsigned MAX_FRAMES   = 1048576;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [ENTRY_W-1:0] PRESENT_FLAG = 64'h8000_0000_0000_0000;
  localparam logic [CNT_W-1:0]   LIMIT_ALL_ONES = 21'h1F_FFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [ENTRY_W-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [CNT_W-1:0]      cfg_data_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;

  int unsigned      outstanding;
  int unsigned      checked;
  int unsigned      mismatches;
  int unsigned      cycle_count = 0;
  int unsigned      entries_sent = 0;
  int unsigned      limits_written = 0;
  int unsigned      rx_hold_asked = 0;
  int unsigned      rx_hold_served = 0;
  bit               tx_gaps_on = 1'b1;
  logic [CNT_W-1:0] frame_limit = TOTAL_RESET;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  page_frame_occupancy_marker_unit #(
    .MAX_FRAMES(MAX_FRAMES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data_i   (cfg_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o)
  );

  frame_occupancy_monitor #(
    .MAX_FRAMES(MAX_FRAMES)
  ) monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data_i   (cfg_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .mismatches_o (mismatches)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  // mix of unmapped words, hot frames that repeat, frames near the limit and wild ones
  function automatic logic [ENTRY_W-1:0] random_entry(logic [CNT_W-1:0] limit_now);
    logic [ENTRY_W-1:0] entry;
    longint unsigned    cap;
    longint unsigned    frame;
    int unsigned        pick;
    entry = {$urandom, $urandom};
    cap = (limit_now > MAX_FRAMES) ? MAX_FRAMES : limit_now;
    frame = entry[FRAME_W-1:0];
    pick = $urandom_range(9);
    case (pick)
      0: ;
      1, 2, 3: frame = $urandom_range(127);
      4, 5: frame = (cap == 0) ? 0 : $urandom_range(cap - 1);
      6: frame = cap + $urandom_range(2) - 1;
      7: frame = $urandom_range(MAX_FRAMES + 1023);
      default: ;
    endcase
    entry[FRAME_W-1:0] = frame[FRAME_W-1:0];
    entry[PRESENT_BIT] = (pick != 0);
    return entry;
  endfunction

  task automatic send_entry(input logic [ENTRY_W-1:0] entry, input logic last);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= entry;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    entries_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frame_limit(input logic [CNT_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frame_limit = value;
    limits_written++;
  endtask

  // output side: random ready stretches, plus one long hold on request
  initial begin
    int unsigned stretch;
    forever begin
      if (rx_hold_asked != rx_hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_served++;
      end
      stretch = $urandom_range(40, 1);
      m_axis_tready <= 1'b1;
      repeat (stretch) @(posedge clk_i);
      stretch = pick_gap();
      if (stretch > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stretch) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_limit;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default limit: unmapped words, first and repeat marks, range edges
    send_entry(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_entry(PRESENT_FLAG, 1'b0);
    send_entry(PRESENT_FLAG, 1'b1);
    send_entry({1'b1, 8'hFF, 55'(MAX_FRAMES - 1)}, 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(MAX_FRAMES), 1'b0);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_entry('0, 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(63), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(64), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(64), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(65), 1'b1);
    drain_results();

    // zero limit: everything out of range, used count above limit
    write_frame_limit('0);
    send_entry(PRESENT_FLAG, 1'b1);
    drain_results();

    // limit above the bitmap size
    write_frame_limit(LIMIT_ALL_ONES);
    send_entry(PRESENT_FLAG | ENTRY_W'(MAX_FRAMES - 1), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(MAX_FRAMES), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(2 * MAX_FRAMES - 2), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(100), 1'b1);
    drain_results();

    // limit lowered under the used count mid-scan
    write_frame_limit(21'd3);
    send_entry(PRESENT_FLAG | ENTRY_W'(2), 1'b0);
    send_entry(PRESENT_FLAG | ENTRY_W'(3), 1'b1);
    drain_results();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: phase_limit = TOTAL_RESET;
        1: phase_limit = 21'd64;
        2: phase_limit = 21'd1000;
        3: phase_limit = 21'd1;
        4: phase_limit = LIMIT_ALL_ONES;
        default: phase_limit = $urandom_range(MAX_FRAMES);
      endcase
      write_frame_limit(phase_limit);
      tx_gaps_on = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 30) rx_hold_asked <= rx_hold_asked + 1;
        if (p == 2 && i == 50) drain_results();
        send_entry(random_entry(frame_limit), 1'($urandom_range(7) == 0));
      end
      drain_results();
    end

    $display("run: %0d map entries over %0d frame-limit writes, %0d result words checked",
             entries_sent, limits_written, checked);
    $display("run: %0d long output stalls, limits from zero to above the bitmap size",
             rx_hold_served);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
